// ----- sv/spa_pkg.sv -----
// Shared types and constants of the sparse polynomial add/subtract block.
package spa_pkg;

    localparam int COEF_W = 32;
    localparam int EXP_W = 16;
    localparam int TERM_W = COEF_W + EXP_W;
    localparam int CMD_W = 3;
    localparam int STAT_W = 2;

    // Longest readout, and the width of a counter that can hold it.
    localparam int MAX_RESULTS = 32;
    localparam int RES_CW = 6;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SUB    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic clear;
        logic load_a;
        logic load_b;
        logic set_ok;
        logic set_empty;
        logic merge_init;
        logic merge_step;
        logic copy_init;
        logic copy_step;
        logic commit;
        logic read_init;
        logic emit_term;
        logic emit_summary;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             out_free;
        logic             tables_empty;
        logic             merge_done;
        logic             copy_done;
        logic             read_done;
    } t_sts;

endpackage

// ----- sv/spa_dp.sv -----
// Datapath: term tables, merge scratch, indices, saturating combiner and output register.
module spa_dp #(
    parameter int MAX_TERMS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spa_pkg::t_ctl               i_ctl,
    output spa_pkg::t_sts               o_sts,
    input  logic [spa_pkg::TERM_W-1:0]  i_s_tdata,
    input  logic [spa_pkg::CMD_W-1:0]   i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [spa_pkg::TERM_W-1:0]  o_m_tdata,
    output logic [3:0]                  o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int TW = (CW + 1 > spa_pkg::RES_CW) ? CW + 1 : spa_pkg::RES_CW;
    localparam int CF = spa_pkg::COEF_W;
    localparam int EF = spa_pkg::EXP_W;

    // Terms are stored as {coefficient, exponent}.
    logic [spa_pkg::TERM_W-1:0] a_mem [MAX_TERMS];
    logic [spa_pkg::TERM_W-1:0] b_mem [MAX_TERMS];
    logic [spa_pkg::TERM_W-1:0] s_mem [MAX_TERMS];

    logic [spa_pkg::TERM_W-1:0] r_a_rd, r_b_rd, r_s_rd;

    logic [spa_pkg::CMD_W-1:0]  r_cmd;
    logic [CF-1:0]              r_coef;
    logic [EF-1:0]              r_exp;

    logic [CW-1:0] r_a_count, r_b_count;
    logic [CW-1:0] r_i, r_j, r_n, r_k;
    logic          r_over;
    logic [TW-1:0] r_emitted;
    logic [spa_pkg::STAT_W-1:0] r_res_status;

    logic                       r_m_tvalid;
    logic [CF-1:0]              r_o_coef;
    logic [EF-1:0]              r_o_exp;
    logic                       r_o_which;
    logic                       r_o_term;
    logic [spa_pkg::STAT_W-1:0] r_o_status;
    logic                       r_o_last;

    logic out_free;
    logic a_avail, b_avail, take_a, take_b, both, sub, skip, a_full, b_full;
    logic signed [CF-1:0] ca, cb, neg_b, comb, mc;
    logic signed [EF-1:0] ea, eb, me;
    logic signed [CF:0]   sum;
    logic [TW-1:0]        total, sum_counts;
    logic                 a_we;
    logic [IW-1:0]        a_waddr;
    logic [spa_pkg::TERM_W-1:0] a_wdata;
    logic                 rd_from_b;

    assign out_free = !r_m_tvalid || i_m_tready;

    assign a_avail = r_i < r_a_count;
    assign b_avail = r_j < r_b_count;
    assign a_full  = r_a_count >= CW'(MAX_TERMS);
    assign b_full  = r_b_count >= CW'(MAX_TERMS);
    assign sub     = r_cmd == spa_pkg::CMD_SUB;

    assign ca = r_a_rd[spa_pkg::TERM_W-1:EF];
    assign ea = r_a_rd[EF-1:0];
    assign cb = r_b_rd[spa_pkg::TERM_W-1:EF];
    assign eb = r_b_rd[EF-1:0];

    always_comb begin
        take_a = !b_avail || (a_avail && (ea < eb));
        take_b = !take_a && (!a_avail || (eb < ea));
        both   = !take_a && !take_b;
        neg_b  = (cb == spa_pkg::COEF_MIN) ? spa_pkg::COEF_MAX : -cb;
        sum    = sub ? ({ca[CF-1], ca} - {cb[CF-1], cb})
                     : ({ca[CF-1], ca} + {cb[CF-1], cb});
        if (sum[CF] != sum[CF-1]) begin
            comb = sum[CF] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
        end else begin
            comb = sum[CF-1:0];
        end
        if (take_a) begin
            mc = ca;
            me = ea;
        end else if (take_b) begin
            mc = sub ? neg_b : cb;
            me = eb;
        end else begin
            mc = comb;
            me = ea;
        end
        skip = both && (comb == '0);
    end

    // Readout is capped at the result limit.
    assign sum_counts = TW'(r_a_count) + TW'(r_b_count);
    assign total = (sum_counts > TW'(spa_pkg::MAX_RESULTS)) ?
                   TW'(spa_pkg::MAX_RESULTS) : sum_counts;
    assign rd_from_b = !a_avail;

    // Table A has one write port, shared by loads and the copy back.
    always_comb begin
        a_we    = 1'b0;
        a_waddr = r_k[IW-1:0];
        a_wdata = r_s_rd;
        if (i_ctl.load_a && !a_full) begin
            a_we    = 1'b1;
            a_waddr = r_a_count[IW-1:0];
            a_wdata = {r_coef, r_exp};
        end else if (i_ctl.copy_step) begin
            a_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            a_mem[a_waddr] <= a_wdata;
        end
        r_a_rd <= a_mem[r_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_b && !b_full) begin
            b_mem[r_b_count[IW-1:0]] <= {r_coef, r_exp};
        end
        r_b_rd <= b_mem[r_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.merge_step && !skip && (r_n < CW'(MAX_TERMS))) begin
            s_mem[r_n[IW-1:0]] <= {mc, me};
        end
        r_s_rd <= s_mem[r_k[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_cmd  <= i_s_tuser;
            r_coef <= i_s_tdata[CF-1:0];
            r_exp  <= i_s_tdata[spa_pkg::TERM_W-1:CF];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_count    <= '0;
            r_b_count    <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_n          <= '0;
            r_k          <= '0;
            r_over       <= 1'b0;
            r_emitted    <= '0;
            r_res_status <= spa_pkg::STAT_OK;
        end else begin
            if (i_ctl.clear) begin
                r_a_count    <= '0;
                r_b_count    <= '0;
                r_res_status <= spa_pkg::STAT_OK;
            end
            if (i_ctl.set_ok) begin
                r_res_status <= spa_pkg::STAT_OK;
            end
            if (i_ctl.set_empty) begin
                r_res_status <= spa_pkg::STAT_EMPTY;
            end
            if (i_ctl.load_a) begin
                if (a_full) begin
                    r_res_status <= spa_pkg::STAT_FULL;
                end else begin
                    r_res_status <= spa_pkg::STAT_OK;
                    r_a_count    <= r_a_count + CW'(1);
                end
            end
            if (i_ctl.load_b) begin
                if (b_full) begin
                    r_res_status <= spa_pkg::STAT_FULL;
                end else begin
                    r_res_status <= spa_pkg::STAT_OK;
                    r_b_count    <= r_b_count + CW'(1);
                end
            end
            if (i_ctl.merge_init || i_ctl.read_init) begin
                r_i       <= '0;
                r_j       <= '0;
                r_n       <= '0;
                r_over    <= 1'b0;
                r_emitted <= '0;
            end
            if (i_ctl.merge_step) begin
                if (take_a || both) begin
                    r_i <= r_i + CW'(1);
                end
                if (take_b || both) begin
                    r_j <= r_j + CW'(1);
                end
                if (!skip) begin
                    if (r_n < CW'(MAX_TERMS)) begin
                        r_n <= r_n + CW'(1);
                    end else begin
                        r_over <= 1'b1;
                    end
                end
            end
            if (i_ctl.copy_init) begin
                r_k <= '0;
            end
            if (i_ctl.copy_step) begin
                r_k <= r_k + CW'(1);
            end
            if (i_ctl.commit) begin
                r_a_count    <= r_n;
                r_res_status <= r_over ? spa_pkg::STAT_FULL : spa_pkg::STAT_OK;
            end
            if (i_ctl.emit_term) begin
                r_emitted <= r_emitted + TW'(1);
                if (rd_from_b) begin
                    r_j <= r_j + CW'(1);
                end else begin
                    r_i <= r_i + CW'(1);
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_ctl.emit_term || i_ctl.emit_summary) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_term) begin
            r_o_which  <= rd_from_b;
            r_o_coef   <= rd_from_b ? r_b_rd[spa_pkg::TERM_W-1:EF] : r_a_rd[spa_pkg::TERM_W-1:EF];
            r_o_exp    <= rd_from_b ? r_b_rd[EF-1:0] : r_a_rd[EF-1:0];
            r_o_term   <= 1'b1;
            r_o_status <= spa_pkg::STAT_OK;
            r_o_last   <= (r_emitted + TW'(1)) == total;
        end else if (i_ctl.emit_summary) begin
            r_o_which  <= 1'b0;
            r_o_coef   <= '0;
            r_o_exp    <= '0;
            r_o_term   <= 1'b0;
            r_o_status <= r_res_status;
            r_o_last   <= 1'b1;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {r_o_exp, r_o_coef};
    assign o_m_tuser  = {r_o_status, r_o_term, r_o_which};
    assign o_m_tlast  = r_o_last;

    assign o_sts.cmd          = r_cmd;
    assign o_sts.out_free     = out_free;
    assign o_sts.tables_empty = (r_a_count == '0) && (r_b_count == '0);
    assign o_sts.merge_done   = !a_avail && !b_avail;
    assign o_sts.copy_done    = r_k >= r_n;
    assign o_sts.read_done    = r_emitted == total;

endmodule

// ----- sv/spa_ctrl.sv -----
// Controller state machine that sequences commands through the datapath.
module spa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  spa_pkg::t_sts i_sts,
    output spa_pkg::t_ctl o_ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_RESULT  = 4'd2;
    localparam logic [3:0] S_M_FETCH = 4'd3;
    localparam logic [3:0] S_M_STEP  = 4'd4;
    localparam logic [3:0] S_C_FETCH = 4'd5;
    localparam logic [3:0] S_C_WRITE = 4'd6;
    localparam logic [3:0] S_R_FETCH = 4'd7;
    localparam logic [3:0] S_R_SEND  = 4'd8;

    logic [3:0] r_state, n_state;

    assign o_s_tready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    spa_pkg::CMD_CLEAR: begin
                        o_ctl.clear = 1'b1;
                        n_state     = S_RESULT;
                    end
                    spa_pkg::CMD_LOAD_A: begin
                        o_ctl.load_a = 1'b1;
                        n_state      = S_RESULT;
                    end
                    spa_pkg::CMD_LOAD_B: begin
                        o_ctl.load_b = 1'b1;
                        n_state      = S_RESULT;
                    end
                    spa_pkg::CMD_ADD, spa_pkg::CMD_SUB: begin
                        o_ctl.merge_init = 1'b1;
                        n_state          = S_M_FETCH;
                    end
                    spa_pkg::CMD_READ: begin
                        if (i_sts.tables_empty) begin
                            o_ctl.set_empty = 1'b1;
                            n_state         = S_RESULT;
                        end else begin
                            o_ctl.read_init = 1'b1;
                            n_state         = S_R_FETCH;
                        end
                    end
                    default: begin
                        o_ctl.set_ok = 1'b1;
                        n_state      = S_RESULT;
                    end
                endcase
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit_summary = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_M_FETCH: begin
                if (i_sts.merge_done) begin
                    o_ctl.copy_init = 1'b1;
                    n_state         = S_C_FETCH;
                end else begin
                    n_state = S_M_STEP;
                end
            end
            S_M_STEP: begin
                o_ctl.merge_step = 1'b1;
                n_state          = S_M_FETCH;
            end
            S_C_FETCH: begin
                if (i_sts.copy_done) begin
                    o_ctl.commit = 1'b1;
                    n_state      = S_RESULT;
                end else begin
                    n_state = S_C_WRITE;
                end
            end
            S_C_WRITE: begin
                o_ctl.copy_step = 1'b1;
                n_state         = S_C_FETCH;
            end
            S_R_FETCH: begin
                n_state = i_sts.read_done ? S_IDLE : S_R_SEND;
            end
            S_R_SEND: begin
                if (i_sts.out_free) begin
                    o_ctl.emit_term = 1'b1;
                    n_state         = S_R_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/sparse_polynomial_add_sub.sv -----
// Top level of the sparse polynomial add/subtract block.
//
// This block keeps two sparse polynomials, A and B, as tables of up to MAX_TERMS
// terms each, meant to be loaded in ascending exponent order (the order is not
// checked). Each request carries one command: clear both tables, append a term
// to A or to B, add or subtract B into A, or read out A followed by B. Every
// command other than read out returns one response with no term and a status
// (0 ok, 1 capacity exceeded, 2 nothing to read). A merge combines terms of
// equal exponent with 32-bit saturation, drops terms that cancel to zero,
// inserts unmatched B terms (negated when subtracting) and keeps the lowest
// MAX_TERMS terms if the result would overflow, flagging status 1. Read out
// returns one response per stored term, at most 32, with tlast on the final
// one; with both tables empty it returns a single status 2 response. Requests
// are taken one at a time. Each table has one registered read port, so every
// merge step first fetches the heads of A and B and then combines them; there
// is one step per term taken from A or B, and a pair of equal exponents
// shares one step, so a merge has at most a_count + b_count steps. Then each
// result term is fetched from the scratch table and copied back into A. Read
// out likewise fetches each term from the registered table read before
// sending it. The output register lets a new request be accepted while the
// last response is still waiting to be taken.
module sparse_polynomial_add_sub #(
    parameter int MAX_TERMS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // Fields from bit 0: coefficient [31:0], exponent [47:32].
    input  logic [spa_pkg::TERM_W-1:0] i_s_tdata,
    // Fields from bit 0: command [2:0].
    input  logic [spa_pkg::CMD_W-1:0]  i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // Fields from bit 0: term_coefficient [31:0], term_exponent [47:32].
    output logic [spa_pkg::TERM_W-1:0] o_m_tdata,
    // Fields from bit 0: which_poly [0], term_valid [1], status [3:2].
    output logic [3:0]                 o_m_tuser,
    output logic                       o_m_tlast
);

    spa_pkg::t_ctl ctl;
    spa_pkg::t_sts sts;

    // The controller only steps through states; all storage lives in the datapath.
    spa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    spa_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
